### rtl/psn_pkg.sv
// ----------------------------------------------------------------------------
// psn_pkg
// shared widths, types and constants of the polyline vertex normal block
// ----------------------------------------------------------------------------
package psn_pkg;

	localparam int MAX_POINTS  = 64;
	localparam int COORD_WIDTH = 16;

	localparam int PTR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SUM_W = COORD_WIDTH + PTR_W;

	// centroid offset n*p - sum and edge normal sums share one vector width
	localparam int R_W   = COORD_WIDTH + PTR_W + 2;
	localparam int VEC_W = (R_W > 18) ? R_W : 18;

	// normalization window [2^NORM_BIT, 2^(NORM_BIT+1))
	localparam int NORM_BIT = 20;
	localparam int MAG_W    = (VEC_W > NORM_BIT + 2) ? VEC_W : NORM_BIT + 2;
	localparam int SQR_W    = 2 * (NORM_BIT + 1);
	localparam int SQ_W     = SQR_W + 2;
	localparam int LEN_W    = NORM_BIT + 2;

	// Q2.14 result
	localparam int Q_W       = 16;
	localparam int Q_FRAC    = 14;
	localparam int NUM_W     = NORM_BIT + 1 + Q_FRAC + 1;
	localparam int DIV_STEPS = Q_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] x;
	} point_t;

	typedef struct packed {
		logic              nonzero;
		logic signed [Q_W-1:0] nx;
		logic signed [Q_W-1:0] ny;
	} uv_res_t;

endpackage

### rtl/psn_point_mem.sv
// ----------------------------------------------------------------------------
// psn_point_mem
// point store, one write and one registered read port
// ----------------------------------------------------------------------------
module psn_point_mem import psn_pkg::*; (
	input  logic             clk,
	input  logic             we,
	input  logic [PTR_W-1:0] waddr,
	input  point_t           wdata,
	input  logic [PTR_W-1:0] raddr,
	output point_t           rdata
);

	point_t mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/psn_unit_vec.sv
// ----------------------------------------------------------------------------
// psn_unit_vec
// iterative normalizer: scale, integer square root, two restoring divides
// ----------------------------------------------------------------------------
module psn_unit_vec import psn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [VEC_W-1:0] a,
	input  logic signed [VEC_W-1:0] b,
	output logic                    done,
	output uv_res_t                 res
);

	typedef enum logic [2:0] {
		U_IDLE, U_SHIFT, U_MUL, U_ADD, U_SQRT, U_SETUP, U_DIV, U_DONE
	} ustate_t;

	ustate_t                state_q;
	logic                   neg_a_q, neg_b_q;
	logic [MAG_W-1:0]       ma_q, mb_q;
	logic [SQR_W-1:0]       sqa_q, sqb_q;
	logic [SQ_W-1:0]        s_q, root_q, bit_q;
	logic [LEN_W-1:0]       len_q, rem_a_q, rem_b_q;
	logic [Q_W-1:0]         num_a_q, num_b_q, qa_q, qb_q;
	logic [DCNT_W-1:0]      cnt_q;
	uv_res_t                res_q;

	logic [VEC_W-1:0]       a_mag, b_mag;
	logic [MAG_W-1:0]       m;
	logic [SQ_W-1:0]        trial;
	logic [LEN_W-1:0]       len_w;
	logic [NUM_W-1:0]       num_a, num_b;
	logic [LEN_W:0]         cand_a, cand_b;
	logic                   ge_a, ge_b;

	assign a_mag = a[VEC_W-1] ? (~a + 1'b1) : a;
	assign b_mag = b[VEC_W-1] ? (~b + 1'b1) : b;
	assign m     = (ma_q > mb_q) ? ma_q : mb_q;
	assign trial = root_q + bit_q;
	assign len_w = root_q[LEN_W-1:0];
	assign num_a = {NUM_W'(ma_q[NORM_BIT:0]) << Q_FRAC} + NUM_W'(len_w >> 1);
	assign num_b = {NUM_W'(mb_q[NORM_BIT:0]) << Q_FRAC} + NUM_W'(len_w >> 1);
	assign cand_a = {rem_a_q, num_a_q[Q_W-1]};
	assign cand_b = {rem_b_q, num_b_q[Q_W-1]};
	assign ge_a   = cand_a >= {1'b0, len_q};
	assign ge_b   = cand_b >= {1'b0, len_q};

	assign done = (state_q == U_DONE);
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			res_q   <= '0;
		end else begin
			case (state_q)
				U_IDLE: begin
					if (start) begin
						neg_a_q <= a[VEC_W-1];
						neg_b_q <= b[VEC_W-1];
						ma_q    <= MAG_W'(a_mag);
						mb_q    <= MAG_W'(b_mag);
						if (a == '0 && b == '0) begin
							res_q   <= '0;
							state_q <= U_DONE;
						end else begin
							state_q <= U_SHIFT;
						end
					end
				end
				U_SHIFT: begin
					// right shifts truncate, left shifts are exact
					if (m[MAG_W-1:NORM_BIT+1] != '0) begin
						ma_q <= ma_q >> 1;
						mb_q <= mb_q >> 1;
					end else if (!m[NORM_BIT]) begin
						ma_q <= ma_q << 1;
						mb_q <= mb_q << 1;
					end else begin
						state_q <= U_MUL;
					end
				end
				U_MUL: begin
					sqa_q   <= SQR_W'(ma_q[NORM_BIT:0]) * SQR_W'(ma_q[NORM_BIT:0]);
					sqb_q   <= SQR_W'(mb_q[NORM_BIT:0]) * SQR_W'(mb_q[NORM_BIT:0]);
					state_q <= U_ADD;
				end
				U_ADD: begin
					s_q     <= SQ_W'(sqa_q) + SQ_W'(sqb_q);
					root_q  <= '0;
					bit_q   <= SQ_W'(1) << (SQ_W - 2);
					state_q <= U_SQRT;
				end
				U_SQRT: begin
					if (s_q >= trial) begin
						s_q    <= s_q - trial;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= U_SETUP;
					end
				end
				U_SETUP: begin
					len_q   <= len_w;
					rem_a_q <= LEN_W'(num_a[NUM_W-1:Q_W]);
					rem_b_q <= LEN_W'(num_b[NUM_W-1:Q_W]);
					num_a_q <= num_a[Q_W-1:0];
					num_b_q <= num_b[Q_W-1:0];
					qa_q    <= '0;
					qb_q    <= '0;
					cnt_q   <= DCNT_W'(DIV_STEPS);
					state_q <= U_DIV;
				end
				U_DIV: begin
					rem_a_q <= ge_a ? LEN_W'(cand_a - {1'b0, len_q}) : cand_a[LEN_W-1:0];
					rem_b_q <= ge_b ? LEN_W'(cand_b - {1'b0, len_q}) : cand_b[LEN_W-1:0];
					num_a_q <= num_a_q << 1;
					num_b_q <= num_b_q << 1;
					qa_q    <= {qa_q[Q_W-2:0], ge_a};
					qb_q    <= {qb_q[Q_W-2:0], ge_b};
					cnt_q   <= cnt_q - 1'b1;
					if (cnt_q == DCNT_W'(1)) begin
						res_q.nonzero <= 1'b1;
						res_q.nx <= neg_a_q ? -$signed({qa_q[Q_W-2:0], ge_a})
						                    : $signed({qa_q[Q_W-2:0], ge_a});
						res_q.ny <= neg_b_q ? -$signed({qb_q[Q_W-2:0], ge_b})
						                    : $signed({qb_q[Q_W-2:0], ge_b});
						state_q <= U_DONE;
					end
				end
				U_DONE: begin
					state_q <= U_IDLE;
				end
				default: begin
					state_q <= U_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/polyline_smooth_normals.sv
// ----------------------------------------------------------------------------
// polyline_smooth_normals
// smooth per-vertex unit normals of a loaded 2d polyline
// ----------------------------------------------------------------------------
// Points arrive one request per cycle and are written into a 64-entry point
// store while running coordinate sums are kept; points past capacity are
// dropped. A request with last_point set ends the profile, after which the
// input stalls and one Q2.14 normal is produced per stored vertex in load
// order. Each vertex takes three store reads, then up to four passes through
// a single shared normalizer (previous edge, next edge, edge sum, and the
// centroid direction when the sum is zero). A full pass scales by single-bit
// shifts into the normalization window, then runs 22 square-root steps and
// 16 divide steps; a zero vector goes straight to done. An orientation check
// and the hand-off follow; a normal needs less work when edges are missing or
// vanish. The normalizer is the rate-setting unit. The output register lets
// the next vertex be computed while a finished normal waits under stall. The
// closed_profile register (reset 1) wraps first and last vertices; write it
// only while the block is idle.
// ----------------------------------------------------------------------------
module polyline_smooth_normals import psn_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          last_point,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [Q_W-1:0]         normal_x,
	output logic signed [Q_W-1:0]         normal_y,
	output logic                          last_normal
);

	typedef enum logic [3:0] {
		T_IDLE, T_RD_CUR, T_RD_PREV, T_RD_NEXT, T_GET_NEXT,
		T_EDGE1, T_WAIT1, T_EDGE2, T_WAIT2, T_SUMN, T_WAITS,
		T_RVEC, T_WAITR, T_DOT, T_SIGN, T_OUT
	} tstate_t;

	localparam int PROD_W = Q_W + VEC_W;

	tstate_t                     state_q;
	logic                        closed_q;
	logic [CNT_W-1:0]            cnt_q;
	logic signed [SUM_W-1:0]     sum_x_q, sum_y_q;
	logic [PTR_W-1:0]            idx_q;
	point_t                      cur_q, prev_q, next_q;
	logic signed [VEC_W-1:0]     rx_q, ry_q;
	logic signed [Q_W:0]         sx_q, sy_q;
	logic signed [Q_W-1:0]       nx_q, ny_q;
	logic signed [PROD_W-1:0]    dot_x_q, dot_y_q;

	logic                        out_valid_q, last_normal_q;
	logic signed [Q_W-1:0]       normal_x_q, normal_y_q;
	logic                        out_load;

	// load side
	logic                        accept, store_we;
	logic [CNT_W-1:0]            cnt_next;

	// vertex addressing
	logic                        last_vtx, has_prev, has_next;
	logic [PTR_W-1:0]            prev_idx, next_idx, raddr;
	point_t                      rdata;

	// edge vectors and centroid offset
	logic signed [COORD_WIDTH:0] dx1, dy1, dx2, dy2;
	logic signed [VEC_W-1:0]     dx1_w, dx2_w, n_w, cx_w, cy_w;
	logic signed [PROD_W-1:0]    nx_w, ny_w, rx_w, ry_w;
	logic signed [PROD_W:0]      dot_sum;

	// normalizer
	logic                        uv_start, uv_done;
	logic signed [VEC_W-1:0]     uv_a, uv_b;
	uv_res_t                     uv_res;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;
	assign store_we = accept && (cnt_q < CNT_W'(MAX_POINTS));
	assign cnt_next = store_we ? cnt_q + 1'b1 : cnt_q;

	assign last_vtx = (CNT_W'(idx_q) + 1'b1) == cnt_q;
	assign has_prev = closed_q || (idx_q != '0);
	assign has_next = closed_q || !last_vtx;
	assign prev_idx = (idx_q == '0) ? PTR_W'(cnt_q - 1'b1) : idx_q - 1'b1;
	assign next_idx = last_vtx ? '0 : idx_q + 1'b1;

	// a finished normal enters the output register when it is empty or draining
	assign out_load = (state_q == T_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		case (state_q)
			T_RD_PREV: raddr = prev_idx;
			T_RD_NEXT: raddr = next_idx;
			default:   raddr = idx_q;
		endcase
	end

	psn_point_mem u_mem (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[PTR_W-1:0]),
		.wdata ({point_y, point_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// edge prev->cur and cur->next, normal is (dy, -dx)
	assign dx1   = {cur_q.x[COORD_WIDTH-1], cur_q.x} - {prev_q.x[COORD_WIDTH-1], prev_q.x};
	assign dy1   = {cur_q.y[COORD_WIDTH-1], cur_q.y} - {prev_q.y[COORD_WIDTH-1], prev_q.y};
	assign dx2   = {next_q.x[COORD_WIDTH-1], next_q.x} - {cur_q.x[COORD_WIDTH-1], cur_q.x};
	assign dy2   = {next_q.y[COORD_WIDTH-1], next_q.y} - {cur_q.y[COORD_WIDTH-1], cur_q.y};
	assign dx1_w = VEC_W'(dx1);
	assign dx2_w = VEC_W'(dx2);

	// n times (point - centroid), the centroid itself is never divided out
	assign n_w  = VEC_W'($signed({1'b0, cnt_q}));
	assign cx_w = VEC_W'(cur_q.x);
	assign cy_w = VEC_W'(cur_q.y);

	always_comb begin
		uv_start = 1'b0;
		uv_a     = VEC_W'(sx_q);
		uv_b     = VEC_W'(sy_q);
		case (state_q)
			T_EDGE1: begin
				uv_start = has_prev;
				uv_a     = VEC_W'(dy1);
				uv_b     = -dx1_w;
			end
			T_EDGE2: begin
				uv_start = has_next;
				uv_a     = VEC_W'(dy2);
				uv_b     = -dx2_w;
			end
			T_SUMN: begin
				uv_start = 1'b1;
			end
			T_RVEC: begin
				uv_start = 1'b1;
				uv_a     = rx_q;
				uv_b     = ry_q;
			end
			default: begin
				uv_start = 1'b0;
			end
		endcase
	end

	psn_unit_vec u_uv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (uv_start),
		.a      (uv_a),
		.b      (uv_b),
		.done   (uv_done),
		.res    (uv_res)
	);

	// orientation check against the centroid direction
	assign nx_w    = PROD_W'(nx_q);
	assign ny_w    = PROD_W'(ny_q);
	assign rx_w    = PROD_W'(rx_q);
	assign ry_w    = PROD_W'(ry_q);
	assign dot_sum = (PROD_W+1)'(dot_x_q) + (PROD_W+1)'(dot_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			closed_q    <= 1'b1;
			cnt_q       <= '0;
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				closed_q <= cfg_data;
			end
			// output register drains independently of the sequencer
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						if (store_we) begin
							sum_x_q <= sum_x_q + SUM_W'(point_x);
							sum_y_q <= sum_y_q + SUM_W'(point_y);
						end
						cnt_q <= cnt_next;
						idx_q <= '0;
						if (last_point && cnt_next != '0) begin
							state_q <= T_RD_CUR;
						end
					end
				end
				T_RD_CUR: begin
					sx_q    <= '0;
					sy_q    <= '0;
					state_q <= T_RD_PREV;
				end
				T_RD_PREV: begin
					cur_q   <= rdata;
					state_q <= T_RD_NEXT;
				end
				T_RD_NEXT: begin
					prev_q  <= rdata;
					rx_q    <= n_w * cx_w - VEC_W'(sum_x_q);
					ry_q    <= n_w * cy_w - VEC_W'(sum_y_q);
					state_q <= T_GET_NEXT;
				end
				T_GET_NEXT: begin
					next_q  <= rdata;
					state_q <= T_EDGE1;
				end
				T_EDGE1: begin
					state_q <= has_prev ? T_WAIT1 : T_EDGE2;
				end
				T_WAIT1: begin
					if (uv_done) begin
						sx_q    <= sx_q + (Q_W+1)'(uv_res.nx);
						sy_q    <= sy_q + (Q_W+1)'(uv_res.ny);
						state_q <= T_EDGE2;
					end
				end
				T_EDGE2: begin
					state_q <= has_next ? T_WAIT2 : T_SUMN;
				end
				T_WAIT2: begin
					if (uv_done) begin
						sx_q    <= sx_q + (Q_W+1)'(uv_res.nx);
						sy_q    <= sy_q + (Q_W+1)'(uv_res.ny);
						state_q <= T_SUMN;
					end
				end
				T_SUMN: begin
					state_q <= T_WAITS;
				end
				T_WAITS: begin
					if (uv_done) begin
						nx_q    <= uv_res.nx;
						ny_q    <= uv_res.ny;
						// zero edge sum falls back to the centroid direction
						state_q <= uv_res.nonzero ? T_DOT : T_RVEC;
					end
				end
				T_RVEC: begin
					state_q <= T_WAITR;
				end
				T_WAITR: begin
					if (uv_done) begin
						nx_q    <= uv_res.nx;
						ny_q    <= uv_res.ny;
						state_q <= T_DOT;
					end
				end
				T_DOT: begin
					dot_x_q <= nx_w * rx_w;
					dot_y_q <= ny_w * ry_w;
					state_q <= T_SIGN;
				end
				T_SIGN: begin
					// flip normals that point toward the centroid
					if (dot_sum < 0) begin
						nx_q <= -nx_q;
						ny_q <= -ny_q;
					end
					state_q <= T_OUT;
				end
				T_OUT: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						normal_x_q    <= nx_q;
						normal_y_q    <= ny_q;
						last_normal_q <= last_vtx;
						if (last_vtx) begin
							cnt_q   <= '0;
							sum_x_q <= '0;
							sum_y_q <= '0;
							state_q <= T_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= T_RD_CUR;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = normal_x_q;
	assign normal_y    = normal_y_q;
	assign last_normal = last_normal_q;

	// store fill never passes capacity
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	// vertex index stays inside the loaded profile while emitting
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_IDLE) |-> (CNT_W'(idx_q) < cnt_q))
		else $error("vertex index outside profile");

	// normalizer results only land in a state that waits for them
	a_uv_done: assert property (@(posedge clk) disable iff (!arst_n)
		uv_done |-> (state_q == T_WAIT1 || state_q == T_WAIT2 ||
		             state_q == T_WAITS || state_q == T_WAITR))
		else $error("normalizer result not awaited");

endmodule
